// File: hdl/tfp_pkg.sv
// Shared types, constants and the CRC fold for the telemetry frame parser.
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

	// Frame geometry: eight payload bytes and a two-byte little-endian checksum.
	localparam int FRAME_BYTES = 10;
	localparam int STORE_DEPTH = FRAME_BYTES - 1;
	localparam int POS_W       = $clog2(FRAME_BYTES);

	// CRC-16/CCITT-FALSE constants.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	// Request codes carried in the input tuser.
	localparam logic [1:0] OP_FEED = 2'd0;
	localparam logic [1:0] OP_TAKE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Timeout register value after reset.
	localparam logic [31:0] TIMEOUT_RESET = 32'd500;

	// Result status codes carried in the output tuser.
	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_FRAME_OK = 3'd1,
		ST_CRC_BAD  = 3'd2,
		ST_GIVEN    = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	// One input word after unpacking.
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data_byte;
		logic [31:0] time_ms;
	} in_item_t;

	// One result word before packing.
	typedef struct packed {
		status_t            status;
		logic [15:0]        rpm;
		logic [15:0]        supply_mv;
		logic [15:0]        load_ma;
		logic signed [15:0] temp_deg;
		logic [15:0]        frame_crc;
		logic [31:0]        record_time_ms;
		logic               stale;
		logic [31:0]        accepted_count;
		logic [31:0]        crc_error_count;
	} result_t;

	// Fold one byte into the running CRC, MSB first, no reflection.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/telemetry_frame_parser.sv
// Top level of the telemetry frame parser.
//
// Requests enter on the slave stream: tuser holds the request code (feed byte,
// take pending record, read newest record), tdata holds the byte and a time in
// milliseconds. Every accepted word produces exactly one result word on the
// master stream: tuser holds the status, tdata the record, the stale flag and
// both frame counters. Bytes form 10-byte frames checked with CRC-16/CCITT-FALSE.
// The user must write the stale timeout via cfg_wen/cfg_wdata only while the block
// idles; the block itself does not enforce this.
// From input acceptance to m_tvalid a word passes the input register, one pass of
// decode, CRC fold and field latch, and then the output register.
// Throughput is one word per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the output register holds its word and the input
// register fills; s_tready drops only while both are full and m_tready is low.
// Reset clears both stages, the frame position, the record, the pending flag
// and the counters, sets the CRC to its initial value and the timeout to 500 ms.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [31:0]  cfg_wdata,   // stale_timeout_ms
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,     // data_byte[7:0], time_ms[39:8]
	input  wire logic [1:0]   s_tuser,     // op[1:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// rpm[15:0], supply_mv[31:16], load_ma[47:32], temp_deg[63:48],
	// frame_crc[79:64], record_time_ms[111:80], stale[112],
	// accepted_count[144:113], crc_error_count[176:145], zero fill[183:177]
	output logic [183:0]      m_tdata,
	output logic [2:0]        m_tuser      // status[2:0]
);

	tfp_pkg::in_item_t item_s1;
	tfp_pkg::result_t  result;
	tfp_pkg::result_t  result_s2;
	logic              item_valid;
	logic              slot_free;
	logic              advance;

	// A word moves through the core when it is present and the output slot frees.
	assign advance = item_valid && slot_free;

	tfp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.advance    (advance),
		.item_valid (item_valid),
		.item_s1    (item_s1)
	);

	tfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item_s1   (item_s1),
		.result    (result)
	);

	tfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result_s2 (result_s2)
	);

	// Pack the result word onto the master stream.
	assign m_tuser = result_s2.status;
	assign m_tdata = {7'b0000000,
	                  result_s2.crc_error_count,
	                  result_s2.accepted_count,
	                  result_s2.stale,
	                  result_s2.record_time_ms,
	                  result_s2.frame_crc,
	                  result_s2.temp_deg,
	                  result_s2.load_ma,
	                  result_s2.supply_mv,
	                  result_s2.rpm};

endmodule

`default_nettype wire

// File: hdl/tfp_in_stage.sv
// Input register stage: captures one request word from the slave stream.
`timescale 1ns / 1ps
`default_nettype none

module tfp_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [39:0]       s_tdata,   // data_byte[7:0], time_ms[39:8]
	input  wire logic [1:0]        s_tuser,   // op[1:0]
	input  wire logic              advance,
	output logic                   item_valid,
	output tfp_pkg::in_item_t      item_s1
);

	logic valid_s1;

	// The stage can take a word when empty or when its word moves on this cycle.
	assign s_tready   = !valid_s1 || advance;
	assign item_valid = valid_s1;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload of the stage; no reset needed.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op        <= s_tuser;
			item_s1.data_byte <= s_tdata[7:0];
			item_s1.time_ms   <= s_tdata[39:8];
		end
	end

endmodule

`default_nettype wire

// File: hdl/tfp_core.sv
// Frame assembly, CRC check, record state and counters; computes one result per word.
`timescale 1ns / 1ps
`default_nettype none

module tfp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              advance,
	input  wire tfp_pkg::in_item_t item_s1,
	output tfp_pkg::result_t       result
);

	logic [tfp_pkg::POS_W-1:0] pos_q, pos_d;
	logic [15:0]               crc_q, crc_d;
	logic [7:0]                store_q [tfp_pkg::STORE_DEPTH];
	logic                      store_we;
	logic [15:0]               rpm_q, volt_q, cur_q, temp_q, fcrc_q;
	logic [31:0]               time_q;
	logic                      latch_rec;
	logic [15:0]               carried;
	logic                      pending_q, pending_d;
	logic                      have_q;
	logic [31:0]               acc_q, acc_d, err_q, err_d;
	logic [31:0]               timeout_q;
	logic [31:0]               age;

	assign carried = {item_s1.data_byte, store_q[tfp_pkg::STORE_DEPTH-1]};
	assign age     = item_s1.time_ms - time_q;

	// Decode the request and work out the result and the next state.
	always_comb begin
		pos_d     = pos_q;
		crc_d     = crc_q;
		store_we  = 1'b0;
		latch_rec = 1'b0;
		pending_d = pending_q;
		acc_d     = acc_q;
		err_d     = err_q;
		result    = '0;
		result.status = tfp_pkg::ST_NONE;

		unique case (item_s1.op)
			tfp_pkg::OP_FEED: begin
				if (pos_q >= tfp_pkg::POS_W'(tfp_pkg::FRAME_BYTES - 1)) begin
					if (carried == crc_q) begin
						latch_rec     = 1'b1;
						pending_d     = 1'b1;
						acc_d         = acc_q + 32'd1;
						result.status = tfp_pkg::ST_FRAME_OK;
					end else begin
						err_d         = err_q + 32'd1;
						result.status = tfp_pkg::ST_CRC_BAD;
					end
					pos_d = '0;
					crc_d = tfp_pkg::CRC_INIT;
				end else begin
					store_we = 1'b1;
					if (pos_q < tfp_pkg::POS_W'(tfp_pkg::FRAME_BYTES - 2)) begin
						crc_d = tfp_pkg::crc_fold(crc_q, item_s1.data_byte);
					end
					pos_d         = pos_q + tfp_pkg::POS_W'(1);
					result.status = tfp_pkg::ST_STORED;
				end
			end
			tfp_pkg::OP_TAKE: begin
				if (pending_q) begin
					result.status = tfp_pkg::ST_GIVEN;
					pending_d     = 1'b0;
				end
			end
			tfp_pkg::OP_READ: begin
				if (have_q) begin
					result.status = tfp_pkg::ST_GIVEN;
					result.stale  = (age > timeout_q);
				end
			end
			default: begin
				result.status = tfp_pkg::ST_NONE;
			end
		endcase

		// Record fields appear only when a record is handed out.
		if (result.status == tfp_pkg::ST_GIVEN) begin
			result.rpm            = rpm_q;
			result.supply_mv      = volt_q;
			result.load_ma        = cur_q;
			result.temp_deg       = temp_q;
			result.frame_crc      = fcrc_q;
			result.record_time_ms = time_q;
		end
		result.accepted_count  = acc_d;
		result.crc_error_count = err_d;
	end

	// Control state and the newest record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= tfp_pkg::CRC_INIT;
			rpm_q     <= '0;
			volt_q    <= '0;
			cur_q     <= '0;
			temp_q    <= '0;
			fcrc_q    <= '0;
			time_q    <= '0;
			pending_q <= 1'b0;
			have_q    <= 1'b0;
			acc_q     <= '0;
			err_q     <= '0;
		end else if (advance) begin
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			pending_q <= pending_d;
			acc_q     <= acc_d;
			err_q     <= err_d;
			if (latch_rec) begin
				rpm_q  <= {store_q[1], store_q[0]};
				volt_q <= {store_q[3], store_q[2]};
				cur_q  <= {store_q[5], store_q[4]};
				temp_q <= {store_q[7], store_q[6]};
				fcrc_q <= carried;
				time_q <= item_s1.time_ms;
				have_q <= 1'b1;
			end
		end
	end

	// Stale timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= tfp_pkg::TIMEOUT_RESET;
		end else if (cfg_wen) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Frame byte store; every entry is written before a frame reads it.
	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			store_q[pos_q] <= item_s1.data_byte;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tfp_out_stage.sv
// Output register stage: holds one result word for the master stream.
`timescale 1ns / 1ps
`default_nettype none

module tfp_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire tfp_pkg::result_t result,
	output logic                  slot_free,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output tfp_pkg::result_t      result_s2
);

	logic valid_s2;

	// The register takes a new word when empty or when its word is taken now.
	assign slot_free = !valid_s2 || m_tready;
	assign m_tvalid  = valid_s2;

	// Valid flag of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tfp_checker.sv
// Port-level checker for the telemetry frame parser and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module tfp_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [183:0] m_tdata,
	input wire logic [2:0]   m_tuser
);

	// A stalled result word holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	// A result word leaves only through a handshake.
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result word dropped without handshake");

	// The input side stalls only when the receiver stalls a waiting word.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output side could move");

	// Record fields and stale flag are zero unless a record is handed out.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != 3'(tfp_pkg::ST_GIVEN)) |-> (m_tdata[112:0] == '0))
		else $error("record fields set without a record");

endmodule

bind telemetry_frame_parser tfp_checker u_tfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/sv/telemetry_frame_parser_tb.sv
// Self-checking testbench for the telemetry frame parser: directed and random traffic.
`timescale 1ns / 1ps
module telemetry_frame_parser_tb;

	// Request code that the block does not define; it must answer with no record.
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_WORDS = 1450;
	localparam int PRINT_CAP    = 100;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_wen   = 1'b0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata   = '0;    // data_byte[7:0], time_ms[39:8]
	logic [1:0]   s_tuser   = '0;    // op[1:0]
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	// rpm, supply_mv, load_ma, temp_deg, frame_crc, record_time_ms,
	// stale, accepted_count, crc_error_count, zero fill (lowest bit first)
	logic [183:0] m_tdata;
	logic [2:0]   m_tuser;           // status[2:0]

	// Parser state as the testbench tracks it.
	int                 frame_pos   = 0;
	logic [15:0]        crc_acc     = tfp_pkg::CRC_INIT;
	logic [7:0]         frame_bytes [tfp_pkg::STORE_DEPTH];
	logic [15:0]        rec_rpm     = '0;
	logic [15:0]        rec_volt    = '0;
	logic [15:0]        rec_curr    = '0;
	logic signed [15:0] rec_temp    = '0;
	logic [15:0]        rec_crc     = '0;
	logic [31:0]        rec_time    = '0;
	bit                 pending     = 1'b0;
	bit                 rec_any     = 1'b0;
	logic [31:0]        ok_total    = '0;
	logic [31:0]        bad_total   = '0;
	logic [31:0]        timeout_ms  = tfp_pkg::TIMEOUT_RESET;

	tfp_pkg::result_t expected_words [$];
	int          words_sent  = 0;
	int          err_count   = 0;
	int          cycle_count = 0;
	int          stall_left  = 0;
	bit          idle_on     = 1'b0;
	logic [31:0] now_ms      = '0;

	telemetry_frame_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #6 clk = ~clk;

	// Run guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("telemetry_frame_parser_tb: done, errors");
			$finish;
		end
	end

	// Bitwise CRC-16/CCITT-FALSE step, most significant data bit first.
	function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = acc[15] ^ b[i];
			acc = {acc[14:0], 1'b0} ^ (fb ? tfp_pkg::CRC_POLY : 16'h0000);
		end
		return acc;
	endfunction

	// Result word that hands out the newest record.
	function automatic tfp_pkg::result_t record_word();
		tfp_pkg::result_t r;
		r = '0;
		r.status = tfp_pkg::ST_GIVEN;
		r.rpm = rec_rpm;
		r.supply_mv = rec_volt;
		r.load_ma = rec_curr;
		r.temp_deg = rec_temp;
		r.frame_crc = rec_crc;
		r.record_time_ms = rec_time;
		return r;
	endfunction

	// Advance the tracked state by one request and return the result it causes.
	function automatic tfp_pkg::result_t predict_word(logic [1:0] op, logic [7:0] b,
			logic [31:0] t);
		tfp_pkg::result_t r;
		logic [15:0] carried;
		logic [31:0] age;
		r = '0;
		r.status = tfp_pkg::ST_NONE;
		case (op)
			tfp_pkg::OP_FEED: begin
				if (frame_pos == tfp_pkg::FRAME_BYTES - 1) begin
					carried = {b, frame_bytes[tfp_pkg::STORE_DEPTH - 1]};
					if (carried == crc_acc) begin
						rec_rpm = {frame_bytes[1], frame_bytes[0]};
						rec_volt = {frame_bytes[3], frame_bytes[2]};
						rec_curr = {frame_bytes[5], frame_bytes[4]};
						rec_temp = {frame_bytes[7], frame_bytes[6]};
						rec_crc = carried;
						rec_time = t;
						pending = 1'b1;
						rec_any = 1'b1;
						ok_total = ok_total + 32'd1;
						r.status = tfp_pkg::ST_FRAME_OK;
					end else begin
						bad_total = bad_total + 32'd1;
						r.status = tfp_pkg::ST_CRC_BAD;
					end
					frame_pos = 0;
					crc_acc = tfp_pkg::CRC_INIT;
				end else begin
					frame_bytes[frame_pos] = b;
					if (frame_pos < tfp_pkg::FRAME_BYTES - 2) begin
						crc_acc = crc_step(crc_acc, b);
					end
					frame_pos++;
					r.status = tfp_pkg::ST_STORED;
				end
			end
			tfp_pkg::OP_TAKE: begin
				if (pending) begin
					r = record_word();
					pending = 1'b0;
				end
			end
			tfp_pkg::OP_READ: begin
				if (rec_any) begin
					age = t - rec_time;
					r = record_word();
					r.stale = (age > timeout_ms);
				end
			end
			default: begin
			end
		endcase
		r.accepted_count = ok_total;
		r.crc_error_count = bad_total;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < PRINT_CAP) begin
			$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		end
		err_count++;
	endtask

	// Compare the word on the master side with one expectation.
	task automatic check_word(input tfp_pkg::result_t want);
		if (m_tuser !== want.status)
			report_mismatch("status", 32'(m_tuser), 32'(want.status));
		if (m_tdata[15:0] !== want.rpm)
			report_mismatch("rpm", 32'(m_tdata[15:0]), 32'(want.rpm));
		if (m_tdata[31:16] !== want.supply_mv)
			report_mismatch("supply_mv", 32'(m_tdata[31:16]), 32'(want.supply_mv));
		if (m_tdata[47:32] !== want.load_ma)
			report_mismatch("load_ma", 32'(m_tdata[47:32]), 32'(want.load_ma));
		if (m_tdata[63:48] !== want.temp_deg)
			report_mismatch("temp_deg", 32'(m_tdata[63:48]), 32'(unsigned'(want.temp_deg)));
		if (m_tdata[79:64] !== want.frame_crc)
			report_mismatch("frame_crc", 32'(m_tdata[79:64]), 32'(want.frame_crc));
		if (m_tdata[111:80] !== want.record_time_ms)
			report_mismatch("record_time_ms", m_tdata[111:80], want.record_time_ms);
		if (m_tdata[112] !== want.stale)
			report_mismatch("stale", 32'(m_tdata[112]), 32'(want.stale));
		if (m_tdata[144:113] !== want.accepted_count)
			report_mismatch("accepted_count", m_tdata[144:113], want.accepted_count);
		if (m_tdata[176:145] !== want.crc_error_count)
			report_mismatch("crc_error_count", m_tdata[176:145], want.crc_error_count);
		if (m_tdata[183:177] !== 7'd0)
			report_mismatch("zero fill", 32'(m_tdata[183:177]), 32'd0);
	endtask

	// Result checker: every accepted word is matched against the oldest expectation.
	always @(posedge clk) begin : result_port
		tfp_pkg::result_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing expected", 32'(m_tuser),
					32'(tfp_pkg::ST_NONE));
			end else begin
				want = expected_words.pop_front();
				check_word(want);
			end
		end
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pick_pause();
		if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
		return $urandom_range(0, 3);
	endfunction

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 99) < 25) begin
			m_tready <= 1'b0;
			stall_left <= pick_pause();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Present one word after an optional gap and wait until it is taken.
	task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [31:0] t);
		int gap;
		gap = (idle_on && $urandom_range(0, 99) < 35) ? pick_pause() + 1 : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {t, b};
		do @(posedge clk); while (s_tready !== 1'b1);
		expected_words.push_back(predict_word(op, b, t));
		words_sent++;
	endtask

	// Read times cluster around the stale threshold of the newest record.
	function automatic logic [31:0] read_time();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) return rec_time + timeout_ms + $urandom_range(0, 3) - 32'd1;
		if (pick < 7) return $urandom();
		return now_ms;
	endfunction

	task automatic send_request();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 8) begin
			send_word(tfp_pkg::OP_TAKE, 8'($urandom()), $urandom());
		end else if (pick < 18) begin
			send_word(tfp_pkg::OP_READ, 8'($urandom()), read_time());
		end else begin
			send_word(OP_SPARE, 8'($urandom()), $urandom());
		end
	endtask

	// Send a ten-byte frame with its checksum; a spoiled frame has one bit flipped.
	task automatic send_frame(input logic [63:0] payload, input bit spoil, input bit chatter);
		logic [7:0] bytes_out [tfp_pkg::FRAME_BYTES];
		logic [15:0] sum;
		int flip;
		sum = tfp_pkg::CRC_INIT;
		for (int i = 0; i < 8; i++) begin
			bytes_out[i] = payload[8*i +: 8];
			sum = crc_step(sum, bytes_out[i]);
		end
		bytes_out[8] = sum[7:0];
		bytes_out[9] = sum[15:8];
		if (spoil) begin
			flip = $urandom_range(0, tfp_pkg::FRAME_BYTES * 8 - 1);
			bytes_out[flip / 8][flip % 8] = ~bytes_out[flip / 8][flip % 8];
		end
		for (int i = 0; i < tfp_pkg::FRAME_BYTES; i++) begin
			if (chatter && $urandom_range(0, 3) == 0) begin
				send_request();
			end
			now_ms = now_ms + $urandom_range(0, 40);
			send_word(tfp_pkg::OP_FEED, bytes_out[i], now_ms);
		end
	endtask

	function automatic logic [15:0] pick_half();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// Feed random bytes until the parser is back at the start of a frame.
	task automatic align_frames();
		while (frame_pos != 0) begin
			send_word(tfp_pkg::OP_FEED, 8'($urandom()), now_ms);
		end
	endtask

	// Drop valid and wait until every expected word has come out.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		timeout_ms = v;
	endtask

	// Take, read and the spare code before any frame has been accepted.
	task automatic test_idle_requests();
		idle_on = 1'b0;
		send_word(tfp_pkg::OP_TAKE, 8'h00, 32'h0000_0000);
		send_word(tfp_pkg::OP_READ, 8'hFF, 32'hFFFF_FFFF);
		send_word(OP_SPARE, 8'hA5, 32'h0000_0000);
	endtask

	// A good frame with extreme fields near the time wrap, then take twice and read twice.
	task automatic test_good_frame();
		idle_on = 1'b1;
		now_ms = 32'hFFFF_FF00;
		send_frame({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF}, 1'b0, 1'b0);
		send_word(tfp_pkg::OP_TAKE, 8'h5A, now_ms);
		send_word(tfp_pkg::OP_TAKE, 8'h00, now_ms);
		send_word(tfp_pkg::OP_READ, 8'h00, rec_time + timeout_ms);
		send_word(tfp_pkg::OP_READ, 8'h00, rec_time + timeout_ms + 32'd1);
	endtask

	// A frame with a corrupted bit: checksum error, no new record.
	task automatic test_bad_frame();
		send_frame({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, 1'b1, 1'b0);
		send_word(tfp_pkg::OP_TAKE, 8'h00, now_ms);
		send_word(tfp_pkg::OP_READ, 8'h00, now_ms);
	endtask

	// Stale flag on both sides of the threshold for several timeout settings.
	task automatic test_stale_thresholds();
		logic [31:0] limits [4];
		limits[0] = 32'h0000_0000;
		limits[1] = 32'hFFFF_FFFF;
		limits[2] = 32'h0000_0001;
		limits[3] = $urandom();
		for (int k = 0; k < 4; k++) begin
			write_timeout(limits[k]);
			send_word(tfp_pkg::OP_READ, 8'($urandom()), rec_time + limits[k]);
			send_word(tfp_pkg::OP_READ, 8'($urandom()), rec_time + limits[k] + 32'd1);
		end
	endtask

	// Random traffic over several timeout settings: mostly valid frames, some
	// corrupted frames, loose requests and misaligned byte noise.
	task automatic test_random_traffic();
		logic [31:0] settings [6];
		int goal;
		int pick;
		int base;
		settings[0] = 32'hFFFF_FFFF;
		settings[1] = 32'h0000_0000;
		settings[2] = $urandom();
		settings[3] = $urandom_range(1, 2000);
		settings[4] = 32'h0000_0001;
		settings[5] = tfp_pkg::TIMEOUT_RESET;
		base = words_sent;
		for (int ph = 0; ph < 6; ph++) begin
			write_timeout(settings[ph]);
			now_ms = $urandom();
			goal = base + (ph + 1) * RANDOM_WORDS / 6;
			while (words_sent < goal) begin
				idle_on = ($urandom_range(0, 3) != 0);
				pick = $urandom_range(0, 19);
				if (pick < 13) begin
					send_frame({pick_half(), pick_half(), pick_half(), pick_half()},
						1'b0, 1'($urandom_range(0, 1)));
				end else if (pick < 15) begin
					send_frame({pick_half(), pick_half(), pick_half(), pick_half()},
						1'b1, 1'($urandom_range(0, 1)));
				end else if (pick < 18) begin
					repeat ($urandom_range(1, 4)) send_request();
				end else begin
					repeat ($urandom_range(1, 12))
						send_word(tfp_pkg::OP_FEED, 8'($urandom()), now_ms);
					align_frames();
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_requests();
		test_good_frame();
		test_bad_frame();
		test_stale_thresholds();
		test_random_traffic();
		settle();
		if (err_count == 0) begin
			$display("telemetry_frame_parser_tb: done, clean");
		end else begin
			$display("telemetry_frame_parser_tb: done, errors");
		end
		$finish;
	end

endmodule
